[sv/mte_pkg.sv]
// Shared types and constants for the MIDI track event encoder.
package mte_pkg;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;
  localparam int MAX_BYTES = 6;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic OP_NOTE = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  localparam logic [7:0] META_BYTE     = 8'hFF;
  localparam logic [7:0] META_EOT_TYPE = 8'h2F;
  localparam logic [7:0] META_EOT_LEN  = 8'h00;
  localparam logic       VLQ_MORE      = 1'b1;
  localparam logic       VLQ_END       = 1'b0;

  // One classified item: the bytes it produces, how many, and whether it ends the track.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      eot;
  } cmd_t;

endpackage

[sv/mte_front.sv]
// Front end: accepts input items, builds their byte lists and tracks running status.
module mte_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mte_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                        s_tuser,
  input  logic                        q_full,
  output logic                        q_push,
  output mte_pkg::cmd_t               q_cmd
);

  logic [20:0] delta_time;
  logic [7:0]  status_byte;
  logic [7:0]  note_number;
  logic [7:0]  velocity;
  logic [7:0]  running_status;
  logic        send_status;
  logic [2:0]  vlq_n;
  logic [2:0]  tail_n;
  logic [2:0][7:0] vlq;
  logic [3:0][7:0] tail;

  assign delta_time  = s_tdata[20:0];
  assign status_byte = s_tdata[28:21];
  assign note_number = s_tdata[36:29];
  assign velocity    = s_tdata[44:37];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  assign send_status = (s_tuser == mte_pkg::OP_NOTE) && (status_byte != running_status);

  always_comb begin
    logic [2:0] pos;
    logic [2:0] k;
    // Delta time as a variable-length quantity, most significant group first.
    if (delta_time[20:7] == 14'd0) begin
      vlq_n = 3'd1;
      vlq   = {8'h00, 8'h00, {mte_pkg::VLQ_END, delta_time[6:0]}};
    end else if (delta_time[20:14] == 7'd0) begin
      vlq_n = 3'd2;
      vlq   = {8'h00, {mte_pkg::VLQ_END, delta_time[6:0]},
               {mte_pkg::VLQ_MORE, delta_time[13:7]}};
    end else begin
      vlq_n = 3'd3;
      vlq   = {{mte_pkg::VLQ_END, delta_time[6:0]}, {mte_pkg::VLQ_MORE, delta_time[13:7]},
               {mte_pkg::VLQ_MORE, delta_time[20:14]}};
    end
    if (s_tuser == mte_pkg::OP_EOT) begin
      tail_n = 3'd3;
      tail   = {8'h00, mte_pkg::META_EOT_LEN, mte_pkg::META_EOT_TYPE, mte_pkg::META_BYTE};
    end else if (send_status) begin
      tail_n = 3'd3;
      tail   = {8'h00, velocity, note_number, status_byte};
    end else begin
      tail_n = 3'd2;
      tail   = {8'h00, 8'h00, velocity, note_number};
    end
    for (int i = 0; i < mte_pkg::MAX_BYTES; i++) begin
      pos = 3'(i);
      k   = pos - vlq_n;
      if (pos < vlq_n) begin
        q_cmd.bytes[i] = vlq[pos[1:0]];
      end else begin
        q_cmd.bytes[i] = tail[k[1:0]];
      end
    end
    q_cmd.count = vlq_n + tail_n;
    q_cmd.eot   = (s_tuser == mte_pkg::OP_EOT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'h00;
    end else if (q_push) begin
      if (s_tuser == mte_pkg::OP_EOT) begin
        running_status <= 8'h00;
      end else if (send_status) begin
        running_status <= status_byte;
      end
    end
  end

endmodule

[sv/mte_queue.sv]
// Short register queue of classified items between the front and back ends.
module mte_queue #(
  parameter int DEPTH = mte_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mte_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output mte_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mte_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/mte_back.sv]
// Back end: outputs queued bytes one per cycle unless stalled; counts track bytes.
module mte_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  mte_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mte_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);

  logic [2:0]  idx;
  logic [31:0] byte_count;
  logic [7:0]  out_byte;
  logic [31:0] track_length;
  logic        load;
  logic        is_last;
  logic [31:0] count_inc;

  assign load      = cmd_valid && (!m_tvalid || m_tready);
  assign is_last   = (idx == cmd.count - 3'd1);
  assign cmd_pop   = load && is_last;
  assign count_inc = byte_count + 32'd1;
  assign m_tdata   = {track_length, out_byte};

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= cmd.bytes[idx];
      track_length <= count_inc;
      m_tlast      <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      idx        <= 3'd0;
      byte_count <= 32'd0;
    end else if (load) begin
      m_tvalid   <= 1'b1;
      idx        <= is_last ? 3'd0 : idx + 3'd1;
      byte_count <= (is_last && cmd.eot) ? 32'd0 : count_inc;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

[sv/midi_track_event_encoder.sv]
// Top level of the MIDI track event encoder.
// Each input item (a note event or an end of track) becomes three to six track bytes on the
// output stream, one byte per beat. A note event gives its delta time as a one- to three-byte
// variable-length quantity, the status byte only when it differs from the running status, then
// the note and velocity bytes; an end of track gives its tail delay and then FF 2F 00, after
// which the byte count and running status restart for the next track. Every output beat carries
// the running track byte count including that byte, so the count on the last byte of an end of
// track is the track length, and tlast marks the last byte of each input item. The output side
// moves one byte per cycle while the receiver is ready; that byte-serial output register sets
// the sustained rate. The front end classifies items at one per cycle into a queue of
// QUEUE_DEPTH entries, so input items are taken back to back while the queue has room, even
// while the output is stalled.
module midi_track_event_encoder #(
  parameter int QUEUE_DEPTH = mte_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // delta_time[20:0], status_byte[28:21], note_number[36:29], velocity[44:37], zero pad
  input  logic [mte_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode: 0 = note event, 1 = end of track
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_byte[7:0], track_length[39:8]
  output logic [mte_pkg::M_TDATA_W-1:0] m_tdata,
  // last_byte: final byte caused by one input item
  output logic                          m_tlast
);

  mte_pkg::cmd_t push_cmd;
  mte_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;

  // Front end: classification and running status.
  mte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Decoupling queue so each side can stall on its own.
  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_cmd    (push_cmd),
    .pop       (q_pop),
    .rd_cmd    (head_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back end: byte serializer and track byte counter.
  mte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

[sv/mte_checker.sv]
// Port-level checks for the MIDI track event encoder, bound to the top level.
module mte_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mte_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // A stalled output item holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // The bytes of one input item follow without gaps.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside the bytes of one item");

  // Inside one input item the track byte count steps by one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tdata[39:8] == 32'($past(m_tdata[39:8]) + 32'd1))
    else $error("track length did not advance by one");

  // Nothing is presented right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (.*);

[dv/tb_midi_track_event_encoder.sv]
// Self-checking testbench for the MIDI track event encoder stream block.
module tb_midi_track_event_encoder;
  import mte_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 270;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic        op;
    logic [20:0] delta;
    logic [7:0]  status;
    logic [7:0]  note;
    logic [7:0]  vel;
  } track_event_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] length;
  } track_byte_t;

  // One directed row. When n_typed is nonzero, the bytes are written out by hand.
  typedef struct packed {
    track_event_t              ev;
    logic [2:0]                n_typed;
    logic [MAX_BYTES-1:0][7:0] typed;
  } table_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          mismatches     = 0;
  int          bytes_checked  = 0;
  int          notes_sent     = 0;
  int          tracks_ended   = 0;
  int unsigned cycles         = 0;

  // Predictor state: running status and the byte count of the current track.
  logic [7:0]  run_status  = '0;
  logic [31:0] track_count = '0;

  track_byte_t track_bytes_q[$];
  table_row_t  dir_tab[$];

  midi_track_event_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic void add_byte(inout cmd_t c, input logic [7:0] b);
    c.bytes[c.count] = b;
    c.count = c.count + 3'd1;
  endfunction

  // Works out the track bytes of one event and updates the running status.
  function automatic cmd_t encode_event(input track_event_t ev);
    cmd_t c;
    c = '0;
    c.eot = (ev.op == OP_EOT);
    // Seven bits per byte, most significant group first.
    if (ev.delta >= 21'd16384) add_byte(c, {VLQ_MORE, ev.delta[20:14]});
    if (ev.delta >= 21'd128) add_byte(c, {VLQ_MORE, ev.delta[13:7]});
    add_byte(c, {VLQ_END, ev.delta[6:0]});
    if (!c.eot) begin
      if (ev.status != run_status) begin
        run_status = ev.status;
        add_byte(c, ev.status);
      end
      add_byte(c, ev.note);
      add_byte(c, ev.vel);
    end else begin
      add_byte(c, META_BYTE);
      add_byte(c, META_EOT_TYPE);
      add_byte(c, META_EOT_LEN);
      run_status = '0;
    end
    return c;
  endfunction

  // Numbers the bytes within the track and queues them; an end of track restarts the count.
  function automatic void queue_track_bytes(input cmd_t c);
    track_byte_t t;
    for (int i = 0; i < int'(c.count); i++) begin
      track_count = track_count + 32'd1;
      t.data = c.bytes[i];
      t.last = (i == int'(c.count) - 1);
      t.length = track_count;
      track_bytes_q.push_back(t);
    end
    if (c.eot) track_count = '0;
  endfunction

  function automatic table_row_t row(input logic op, input logic [20:0] dt,
                                     input logic [7:0] st, input logic [7:0] nt,
                                     input logic [7:0] vl, input int n = 0,
                                     input logic [7:0] b0 = 8'h00, input logic [7:0] b1 = 8'h00,
                                     input logic [7:0] b2 = 8'h00, input logic [7:0] b3 = 8'h00,
                                     input logic [7:0] b4 = 8'h00, input logic [7:0] b5 = 8'h00);
    table_row_t r;
    r.ev = '{op: op, delta: dt, status: st, note: nt, vel: vl};
    r.n_typed = 3'(n);
    r.typed = {b5, b4, b3, b2, b1, b0};
    return r;
  endfunction

  // Mostly well-formed tracks: a few common status bytes so that running status
  // is hit often, with the occasional zero or random status, and all VLQ sizes.
  function automatic track_event_t random_event();
    track_event_t ev;
    ev.op = ($urandom_range(99) < 8) ? OP_EOT : OP_NOTE;
    case ($urandom_range(3))
      0: ev.delta = 21'($urandom_range(127));
      1: ev.delta = 21'($urandom_range(16383, 128));
      2: ev.delta = 21'($urandom_range(2097151, 16384));
      default: ev.delta = 21'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1, 2: ev.status = 8'h90;
      3, 4: ev.status = 8'h80;
      5: ev.status = 8'hB0;
      6: ev.status = 8'h00;
      default: ev.status = 8'($urandom);
    endcase
    ev.note = 8'($urandom);
    ev.vel = 8'($urandom);
    return ev;
  endfunction

  // Presents one event after a random gap and returns at the edge where it is taken.
  task automatic send_event(input track_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= S_TDATA_W'({$urandom, $urandom});
      s_tuser <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.op;
    s_tdata <= {3'b000, ev.vel, ev.note, ev.status, ev.delta};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (ev.op == OP_EOT) tracks_ended++;
    else notes_sent++;
  endtask

  // Holds the input idle until every queued track byte has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (track_bytes_q.size() != 0);
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    track_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (track_bytes_q.size() == 0) begin
        mismatches++;
        $display("%0t: byte with none expected, actual byte %h length %0d last %b",
                 $time, m_tdata[7:0], m_tdata[39:8], m_tlast);
      end else begin
        want = track_bytes_q.pop_front();
        bytes_checked++;
        if (m_tdata[7:0] !== want.data) begin
          mismatches++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata[7:0]);
        end
        if (m_tdata[39:8] !== want.length) begin
          mismatches++;
          $display("%0t: track_length expected %0d actual %0d", $time, want.length,
                   m_tdata[39:8]);
        end
        if (m_tlast !== want.last) begin
          mismatches++;
          $display("%0t: last_byte expected %b actual %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles,
               track_bytes_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    track_event_t ev;
    cmd_t         c;

    // Directed rows: empty running status, VLQ size edges, both meta paths, bit patterns.
    dir_tab.push_back(row(OP_NOTE, 0, 8'h00, 8'h00, 8'h00, 3, 8'h00, 8'h00, 8'h00));
    dir_tab.push_back(row(OP_NOTE, 127, 8'h90, 8'h3C, 8'h7F, 4, 8'h7F, 8'h90, 8'h3C, 8'h7F));
    dir_tab.push_back(row(OP_NOTE, 128, 8'h90, 8'hFF, 8'hFF, 4, 8'h81, 8'h00, 8'hFF, 8'hFF));
    dir_tab.push_back(row(OP_NOTE, 16383, 8'h80, 8'h00, 8'h80, 5,
                          8'hFF, 8'h7F, 8'h80, 8'h00, 8'h80));
    dir_tab.push_back(row(OP_NOTE, 16384, 8'hFF, 8'h55, 8'hAA, 6,
                          8'h81, 8'h80, 8'h00, 8'hFF, 8'h55, 8'hAA));
    dir_tab.push_back(row(OP_NOTE, 2097151, 8'hFF, 8'hAA, 8'h55, 5,
                          8'hFF, 8'hFF, 8'h7F, 8'hAA, 8'h55));
    dir_tab.push_back(row(OP_EOT, 0, 8'hAB, 8'hCD, 8'hEF, 4, 8'h00, 8'hFF, 8'h2F, 8'h00));
    dir_tab.push_back(row(OP_EOT, 2097151, 8'hFF, 8'hFF, 8'hFF, 6,
                          8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h2F, 8'h00));
    dir_tab.push_back(row(OP_NOTE, 5, 8'h00, 8'h11, 8'h22, 3, 8'h05, 8'h11, 8'h22));
    dir_tab.push_back(row(OP_EOT, 200, 8'h00, 8'h00, 8'h00, 5,
                          8'h81, 8'h48, 8'hFF, 8'h2F, 8'h00));
    dir_tab.push_back(row(OP_NOTE, 21'h0AAAAA, 8'h55, 8'hAA, 8'h55));
    dir_tab.push_back(row(OP_NOTE, 21'h155555, 8'hAA, 8'h55, 8'hAA));
    dir_tab.push_back(row(OP_NOTE, 21'h000040, 8'hAA, 8'h01, 8'hFE));
    dir_tab.push_back(row(OP_NOTE, 21'h003FFF, 8'h00, 8'h80, 8'h7F));
    dir_tab.push_back(row(OP_EOT, 21'h004000, 8'h12, 8'h34, 8'h56));
    dir_tab.push_back(row(OP_NOTE, 21'h1FFFFF, 8'h90, 8'h40, 8'h40));
    dir_tab.push_back(row(OP_NOTE, 21'h000001, 8'h90, 8'h40, 8'h00));
    dir_tab.push_back(row(OP_EOT, 21'h00007F, 8'h00, 8'h00, 8'h00));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_event(dir_tab[i].ev);
      c = encode_event(dir_tab[i].ev);
      if (dir_tab[i].n_typed != 0) begin
        c.bytes = dir_tab[i].typed;
        c.count = dir_tab[i].n_typed;
      end
      queue_track_bytes(c);
    end
    wait_drained();

    // Slow sender with a busy receiver, then the reverse, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 28 : (ph == 1) ? 64 : 0;
      recv_stall_pct = (ph == 0) ? 64 : (ph == 1) ? 28 : 0;
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
        ev = random_event();
        send_event(ev);
        queue_track_bytes(encode_event(ev));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d note events and %0d end-of-track items; checked %0d track bytes.",
             notes_sent, tracks_ended, bytes_checked);
    $display("Idling was applied on each side in turn, followed by a phase without idling.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
